>>> rtl/lsvc_pkg.sv
`timescale 1ns / 1ps
package lsvc_pkg;

	localparam int COORD_WIDTH     = 24;
	localparam int COORD_FRAC_BITS = 8;
	localparam int PARAM_FRAC_BITS = 16;
	localparam int REG_BITS        = 13;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// deltas, edge offsets and their magnitudes
	localparam int DW = COORD_WIDTH + 1;
	localparam int QW = ((COORD_WIDTH > REG_BITS + COORD_FRAC_BITS + 1) ?
		COORD_WIDTH : REG_BITS + COORD_FRAC_BITS + 1) + 1;
	localparam int MW = QW;
	// quotient bits, clamped quotient, clip parameter, product
	localparam int QBITS = PARAM_FRAC_BITS + 1;
	localparam int TW    = PARAM_FRAC_BITS + 2;
	localparam int PW    = PARAM_FRAC_BITS + 1;
	localparam int PRW   = PW + 1 + DW;

	localparam logic REG_IDX_WIDTH  = 1'b0;
	localparam logic REG_IDX_HEIGHT = 1'b1;

	localparam logic [REG_BITS-1:0] WIDTH_RESET  = REG_BITS'(320);
	localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(240);

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
	} in_item_t;

	typedef struct packed {
		logic                          visible;
		logic signed [COORD_WIDTH-1:0] clip_start_x;
		logic signed [COORD_WIDTH-1:0] clip_start_y;
		logic signed [COORD_WIDTH-1:0] clip_end_x;
		logic signed [COORD_WIDTH-1:0] clip_end_y;
	} out_item_t;

	typedef struct packed {
		logic [MW-1:0] rem;
		logic [MW-1:0] den;
	} div_in_t;

endpackage

>>> rtl/lsvc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage, MSB first.
module lsvc_div import lsvc_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  div_in_t          din,
	output logic [QBITS-1:0] quo
);

	logic [MW-1:0]    rem_sd [QBITS];
	logic [MW-1:0]    den_sd [QBITS];
	logic [QBITS-1:0] quo_sd [QBITS];

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		logic [MW:0]      trial;
		logic [MW-1:0]    prev_den;
		logic [QBITS-1:0] prev_quo;
		logic             ge;

		if (k == 0) begin : g_first
			assign trial    = {1'b0, din.rem};
			assign prev_den = din.den;
			assign prev_quo = '0;
		end else begin : g_next
			assign trial    = {rem_sd[k-1], 1'b0};
			assign prev_den = den_sd[k-1];
			assign prev_quo = quo_sd[k-1];
		end

		assign ge = trial >= {1'b0, prev_den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k] <= ge ? MW'(trial - {1'b0, prev_den}) : trial[MW-1:0];
				den_sd[k] <= prev_den;
				quo_sd[k] <= {prev_quo[QBITS-2:0], ge};
			end
		end
	end

	assign quo = quo_sd[QBITS-1];

endmodule

>>> rtl/line_segment_viewport_clip.sv
`timescale 1ns / 1ps
// Pipeline: stage 1, stage 2, the divider stages, stages T, E and M, then the output register;
// the divider resolves one quotient bit per stage.
// Throughput: one segment per cycle; the whole pipeline holds while a result is stalled.
// Reset: asynchronous, active low; clears every stage valid and loads width 320,
// height 240. Payload registers are not reset.
module line_segment_viewport_clip import lsvc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam logic signed [TW-1:0] T_MAX = TW'((64'd1 << PARAM_FRAC_BITS) + 64'd1);
	localparam logic signed [TW-1:0] T_ONE = TW'(64'd1 << PARAM_FRAC_BITS);
	localparam logic signed [PRW-1:0] HALF = PRW'(64'd1 << (PARAM_FRAC_BITS - 1));

	// sideband that rides alongside the divider
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x0;
		logic signed [COORD_WIDTH-1:0] y0;
		logic signed [COORD_WIDTH-1:0] x1;
		logic signed [COORD_WIDTH-1:0] y1;
		logic signed [DW-1:0]          dx;
		logic signed [DW-1:0]          dy;
		logic [3:0]                    pzero;
		logic [3:0]                    pneg;
		logic [3:0]                    qneg;
		logic [3:0]                    tneg;
		logic [3:0]                    sat;
	} side_t;

	// configuration registers
	logic [REG_BITS-1:0] view_width_q;
	logic [REG_BITS-1:0] view_height_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q  <= WIDTH_RESET;
			view_height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_IDX_WIDTH:  view_width_q  <= pwdata[REG_BITS-1:0];
				REG_IDX_HEIGHT: view_height_q <= pwdata[REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IDX_HEIGHT: prdata = APB_DATA_W'(view_height_q);
			default:        prdata = APB_DATA_W'(view_width_q);
		endcase
	end

	// Global advance: every stage moves together unless the output transaction is held.
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	logic             vld_s1, vld_s2, vld_st, vld_se, vld_sm;
	logic [QBITS-1:0] vld_sd;

	// ---- stage 1: deltas, edge offsets q and directions p (left, right, top, bottom)
	logic signed [REG_BITS:0] wm1_c, hm1_c;
	logic signed [QW-1:0]     right_c, bottom_c;
	logic signed [DW-1:0]     dx_c, dy_c;

	assign wm1_c    = {1'b0, view_width_q} - 1'b1;
	assign hm1_c    = {1'b0, view_height_q} - 1'b1;
	assign right_c  = QW'(wm1_c) <<< COORD_FRAC_BITS;
	assign bottom_c = QW'(hm1_c) <<< COORD_FRAC_BITS;
	assign dx_c     = DW'(in_data.end_x) - DW'(in_data.start_x);
	assign dy_c     = DW'(in_data.end_y) - DW'(in_data.start_y);

	in_item_t             pt_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [QW-1:0] q_s1 [4];
	logic signed [DW-1:0] p_s1 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1   <= in_data;
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			q_s1[0] <= QW'(in_data.start_x);
			q_s1[1] <= right_c - QW'(in_data.start_x);
			q_s1[2] <= QW'(in_data.start_y);
			q_s1[3] <= bottom_c - QW'(in_data.start_y);
			p_s1[0] <= -dx_c;
			p_s1[1] <= dx_c;
			p_s1[2] <= -dy_c;
			p_s1[3] <= dy_c;
		end
	end

	// ---- stage 2: magnitudes, sign flags, saturation when the quotient reaches two
	side_t   side_c2, side_s2;
	div_in_t div_c2 [4];
	div_in_t div_s2 [4];

	always_comb begin
		logic [MW-1:0] r;
		logic [MW-1:0] d;
		side_c2.x0 = pt_s1.start_x;
		side_c2.y0 = pt_s1.start_y;
		side_c2.x1 = pt_s1.end_x;
		side_c2.y1 = pt_s1.end_y;
		side_c2.dx = dx_s1;
		side_c2.dy = dy_s1;
		for (int e = 0; e < 4; e++) begin
			r = q_s1[e][QW-1] ? MW'(-q_s1[e]) : MW'(q_s1[e]);
			d = p_s1[e][DW-1] ? MW'(-p_s1[e]) : MW'(p_s1[e]);
			div_c2[e].rem    = r;
			div_c2[e].den    = d;
			side_c2.pzero[e] = (p_s1[e] == '0);
			side_c2.pneg[e]  = p_s1[e][DW-1];
			side_c2.qneg[e]  = q_s1[e][QW-1];
			side_c2.tneg[e]  = (q_s1[e][QW-1] != p_s1[e][DW-1]) && (q_s1[e] != '0);
			side_c2.sat[e]   = {1'b0, r} >= {d, 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_c2;
			div_s2  <= div_c2;
		end
	end

	// ---- divider stages: one lane per edge, sideband delayed to match
	logic [QBITS-1:0] quo [4];

	for (genvar e = 0; e < 4; e++) begin : g_lane
		lsvc_div u_div (
			.clk (clk),
			.en  (adv),
			.din (div_s2[e]),
			.quo (quo[e])
		);
	end

	side_t side_sd [QBITS];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sd[0] <= side_s2;
			for (int k = 1; k < QBITS; k++) begin
				side_sd[k] <= side_sd[k-1];
			end
		end
	end

	// ---- stage T: clamp quotients to just outside [0,1]
	side_t                side_st;
	logic signed [TW-1:0] t_st [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_st <= side_sd[QBITS-1];
			for (int e = 0; e < 4; e++) begin
				priority if (side_sd[QBITS-1].tneg[e]) begin
					t_st[e] <= '1;
				end else if (side_sd[QBITS-1].sat[e] || $signed({1'b0, quo[e]}) > T_MAX) begin
					t_st[e] <= T_MAX;
				end else begin
					t_st[e] <= $signed({1'b0, quo[e]});
				end
			end
		end
	end

	// ---- stage E: the left, right, top and bottom edge tests in order
	logic                 vis_c;
	logic signed [TW-1:0] lo_c, hi_c;

	always_comb begin
		vis_c = 1'b1;
		lo_c  = '0;
		hi_c  = T_ONE;
		for (int e = 0; e < 4; e++) begin
			if (vis_c) begin
				priority if (side_st.pzero[e]) begin
					// parallel to the edge: inside or out, no narrowing
					if (side_st.qneg[e]) vis_c = 1'b0;
				end else if (side_st.pneg[e]) begin
					if (t_st[e] > hi_c) vis_c = 1'b0;
					else if (t_st[e] > lo_c) lo_c = t_st[e];
				end else begin
					if (t_st[e] < lo_c) vis_c = 1'b0;
					else if (t_st[e] < hi_c) hi_c = t_st[e];
				end
			end
		end
	end

	side_t         side_se;
	logic          vis_se;
	logic [PW-1:0] lo_se, hi_se;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_se <= side_st;
			vis_se  <= vis_c;
			lo_se   <= lo_c[PW-1:0];
			hi_se   <= hi_c[PW-1:0];
		end
	end

	// ---- stage M: parameter times delta
	side_t                 side_sm;
	logic                  vis_sm;
	logic signed [PRW-1:0] prod_sm [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sm    <= side_se;
			vis_sm     <= vis_se;
			prod_sm[0] <= $signed({1'b0, lo_se}) * side_se.dx;
			prod_sm[1] <= $signed({1'b0, lo_se}) * side_se.dy;
			prod_sm[2] <= $signed({1'b0, hi_se}) * side_se.dx;
			prod_sm[3] <= $signed({1'b0, hi_se}) * side_se.dy;
		end
	end

	// ---- output stage: round to nearest (halves up) and add the base point
	logic signed [COORD_WIDTH-1:0] off_c [4];

	always_comb begin
		for (int e = 0; e < 4; e++) begin
			off_c[e] = COORD_WIDTH'((prod_sm[e] + HALF) >>> PARAM_FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.visible <= vis_sm;
			if (vis_sm) begin
				out_data.clip_start_x <= side_sm.x0 + off_c[0];
				out_data.clip_start_y <= side_sm.y0 + off_c[1];
				out_data.clip_end_x   <= side_sm.x0 + off_c[2];
				out_data.clip_end_y   <= side_sm.y0 + off_c[3];
			end else begin
				// rejected: pass the segment through
				out_data.clip_start_x <= side_sm.x0;
				out_data.clip_start_y <= side_sm.y0;
				out_data.clip_end_x   <= side_sm.x1;
				out_data.clip_end_y   <= side_sm.y1;
			end
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_sd    <= '0;
			vld_st    <= 1'b0;
			vld_se    <= 1'b0;
			vld_sm    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_sd    <= {vld_sd[QBITS-2:0], vld_s2};
			vld_st    <= vld_sd[QBITS-1];
			vld_se    <= vld_st;
			vld_sm    <= vld_se;
			out_valid <= vld_sm;
		end
	end

	// a visible segment keeps its entry parameter at or below its exit parameter
	a_lo_le_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_se && vis_se) |-> (lo_se <= hi_se))
		else $error("entry parameter above exit parameter");

	a_hi_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_se && vis_se) |-> (hi_se <= PW'(T_ONE)))
		else $error("exit parameter above one");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({vld_s1, vld_s2, vld_sd, vld_st, vld_se, vld_sm, out_valid}))
		else $error("pipeline moved while held");

endmodule
